// File: rtl/apct_pkg.sv
// Shared types, constants and helpers for the audio play cursor tracker.
// No dependencies; every other file imports this package.
package apct_pkg;

    // Field and state widths
    localparam int SIZE_BITS      = 24;
    localparam int TIME_BITS      = 48;
    localparam int RATE_BITS      = 20;
    localparam int FRAME_BITS     = 7;
    localparam int FRAC_BITS      = 10;
    localparam int FLAG_BITS      = 8;
    localparam int CMD_BITS       = 3;
    localparam int CFG_IDX_BITS   = 2;
    localparam int STALL_LIMIT_MS = 100;
    localparam int MS_PER_S       = 1000;

    // Datapath widths
    localparam int PROD_BITS    = SIZE_BITS + RATE_BITS;
    localparam int DIVN_BITS    = TIME_BITS;
    localparam int DIVD_BITS    = SIZE_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIVN_BITS);
    localparam int T_BITS       = SIZE_BITS + 2;

    // Divide by one thousand, one 16-bit digit per cycle by reciprocal multiply
    localparam int K_DIG_BITS   = 16;
    localparam int K_STEPS      = TIME_BITS / K_DIG_BITS;
    localparam int K_CNT_BITS   = 2;
    localparam int K_T_BITS     = FRAC_BITS + K_DIG_BITS;
    localparam int K_MAGIC_BITS = 29;
    localparam int K_M_BITS     = K_T_BITS + K_MAGIC_BITS;
    localparam int K_SHIFT      = 38;
    localparam logic [K_MAGIC_BITS-1:0] K_MAGIC = 29'h10624DD3;

    // Register reset values
    localparam logic [SIZE_BITS-1:0]  RST_BUF_SIZE   = SIZE_BITS'(65536);
    localparam logic [FRAME_BITS-1:0] RST_FRAME      = FRAME_BITS'(4);
    localparam logic [SIZE_BITS-1:0]  RST_LOOP_START = '0;
    localparam logic [RATE_BITS-1:0]  RST_DEF_RATE   = RATE_BITS'(48000);

    // Input word layout, lowest bit first
    localparam int IN_CMD_LO   = 0;
    localparam int IN_NOW_LO   = IN_CMD_LO + CMD_BITS;
    localparam int IN_FLAGS_LO = IN_NOW_LO + TIME_BITS;
    localparam int IN_NPOS_LO  = IN_FLAGS_LO + FLAG_BITS;
    localparam int IN_RATE_LO  = IN_NPOS_LO + SIZE_BITS;
    localparam int IN_BITS     = IN_RATE_LO + RATE_BITS;
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;

    // Output word layout, lowest bit first
    localparam int OUT_BITS       = 1 + SIZE_BITS + 1 + 1 + SIZE_BITS + SIZE_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INIT    = 3'd0,
        CMD_QUERY   = 3'd1,
        CMD_CONSUME = 3'd2,
        CMD_PLAY    = 3'd3,
        CMD_STOP    = 3'd4,
        CMD_SETPOS  = 3'd5,
        CMD_SETFREQ = 3'd6
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BUF_SIZE   = 2'd0,
        REG_FRAME      = 2'd1,
        REG_LOOP_START = 2'd2,
        REG_DEF_RATE   = 2'd3
    } t_reg;

    // Datapath operations issued by the controller
    typedef enum logic [5:0] {
        OP_NONE, OP_LOAD, OP_FINISH,
        OP_EL, OP_REM, OP_LF, OP_T, OP_STOPEND,
        OP_INIT, OP_PLAY, OP_STOP, OP_SETPOS, OP_SETFREQ,
        D_SZMOD, D_LSMOD, D_NPMOD, D_EL1000, D_FRAC1000, D_FRAMES, D_POS,
        D_REMRATE, D_LS, D_SECLF, D_PRODLF, D_REMLF, D_ADVLF, D_FR1000, D_LEFT,
        M_ELM, M_SECRATE, M_S1RATE, M_ELRATE, M_CURFWD, M_CURLOOP, M_LEN
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE, S_CHK_SZ, S_CHK_LS, S_DISPATCH, S_NPMOD,
        S_A_START, S_A_EL1000, S_A_MULELM, S_A_FRAC1000, S_A_FRAMES, S_A_POS,
        S_A_REM, S_A_REMRATE, S_A_SECRATE, S_A_COND2, S_A_CURFWD, S_A_WRAP,
        S_A_LS, S_A_LF, S_A_SECLF, S_A_S1RATE, S_A_PRODLF, S_A_REMLF, S_A_T,
        S_A_ADVLF, S_A_CURLOOP, S_POST, S_C_ELRATE, S_C_FR1000, S_C_LEFT, S_C_LEN,
        S_APPLY, S_FINISH
    } t_state;

    typedef struct packed {
        t_op  op;
        logic status;
        logic cur_zero;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic div_done;
        logic div_rem_zero;
        logic cfg_ok;
        logic init_ok;
        logic can_adv;
        logic cond1;
        logic cond2;
        logic loop_mode;
        logic el_in_limit;
        logic flags_bad;
        logic npos_ge_size;
        logic rsel_zero;
        logic out_busy;
    } t_sts;

    // Ops that run on the shared divider (variable divisor)
    function automatic logic is_div(input t_op op);
        logic r;
        r = (op == D_SZMOD)   || (op == D_LSMOD)   || (op == D_NPMOD)  ||
            (op == D_FRAMES)  || (op == D_POS)     || (op == D_REMRATE) ||
            (op == D_LS)      || (op == D_SECLF)   || (op == D_PRODLF) ||
            (op == D_REMLF)   || (op == D_ADVLF)   || (op == D_LEFT);
        return r;
    endfunction

    // Ops that divide by one thousand
    function automatic logic is_kdiv(input t_op op);
        logic r;
        r = (op == D_EL1000) || (op == D_FRAC1000) || (op == D_FR1000);
        return r;
    endfunction

endpackage

// File: rtl/apct_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on apct_pkg for the dividend and divisor widths.
module apct_div
    import apct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIVN_BITS-1:0] i_dividend,
    input  logic [DIVD_BITS-1:0] i_divisor,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [DIVN_BITS-1:0] o_quot,
    output logic [DIVD_BITS-1:0] o_rem
);

    logic                    r_busy, r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DIVN_BITS-1:0]    r_q;
    logic [DIVD_BITS-1:0]    r_r;
    logic [DIVD_BITS-1:0]    r_dsr;
    logic [DIVD_BITS:0]      trial;
    logic                    qbit;
    logic [DIVD_BITS-1:0]    n_r;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        trial = {r_r, r_q[DIVN_BITS-1]} - {1'b0, r_dsr};
        qbit  = !trial[DIVD_BITS];
        n_r   = qbit ? trial[DIVD_BITS-1:0] : {r_r[DIVD_BITS-2:0], r_q[DIVN_BITS-1]};
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_BITS'(DIVN_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Shift quotient bits in, hold the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_r   <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DIVN_BITS-2:0], qbit};
            r_r <= n_r;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// File: rtl/apct_dp.sv
// Datapath: configuration registers, cursor state, temporaries, the shared
// multiplier, the divider instance and the output register. Uses apct_pkg, apct_div.
module apct_dp
    import apct_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [SIZE_BITS-1:0]      i_cfg_data,
    input  logic [IN_TDATA_BITS-1:0]  i_in_data,
    input  t_ctl                      i_ctl,
    output t_sts                      o_sts,
    input  logic                      i_m_axis_tready,
    output logic                      o_m_axis_tvalid,
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    // Configuration and persistent state
    logic [SIZE_BITS-1:0]  r_size, r_loop, r_cur;
    logic [FRAME_BITS-1:0] r_frame;
    logic [RATE_BITS-1:0]  r_def, r_rate;
    logic [FRAC_BITS-1:0]  r_frac;
    logic [TIME_BITS-1:0]  r_last;
    logic                  r_run, r_loopm, r_out_valid;

    // Captured command word
    t_cmd                  r_cmd;
    logic [TIME_BITS-1:0]  r_now;
    logic [FLAG_BITS-1:0]  r_flags;
    logic [SIZE_BITS-1:0]  r_npos;
    logic [RATE_BITS-1:0]  r_nrate;

    // Temporaries
    logic [TIME_BITS-1:0]  r_el, r_sec;
    logic [FRAC_BITS-1:0]  r_elm, r_f0;
    logic [PROD_BITS-1:0]  r_prod;
    logic [SIZE_BITS-1:0]  r_fq, r_frames, r_pos, r_rem, r_ls, r_lf;
    logic [SIZE_BITS-1:0]  r_s1, r_s2, r_s3, r_s4, r_p, r_fr, r_len;
    logic [T_BITS-1:0]     r_t;
    logic                  r_szok, r_lsok, r_cvalid;

    // Output word
    logic                  r_o_status, r_o_play, r_o_cv;
    logic [SIZE_BITS-1:0]  r_o_cur, r_o_off, r_o_len;

    // Divide-by-thousand unit
    logic [TIME_BITS-1:0]  r_kx, r_kq;
    logic [FRAC_BITS-1:0]  r_kr;
    logic [K_CNT_BITS-1:0] r_kcnt;
    logic                  r_kbusy, r_kdone;
    logic [TIME_BITS-1:0]  k_n;
    logic                  k_start;
    logic [K_T_BITS-1:0]   k_t, k_q1000, k_rem;
    logic [K_M_BITS-1:0]   k_m;
    logic [K_DIG_BITS-1:0] k_qd;

    logic [DIVN_BITS-1:0]  div_n, div_q;
    logic [DIVD_BITS-1:0]  div_d, div_r;
    logic                  div_start, div_busy, div_done;
    logic [SIZE_BITS-1:0]  mul_a;
    logic [RATE_BITS-1:0]  mul_b;
    logic [PROD_BITS-1:0]  mul_p, sum;
    logic [RATE_BITS-1:0]  rsel;
    logic [SIZE_BITS-1:0]  left_n;
    t_op                   op;

    assign op     = i_ctl.op;
    assign rsel   = (r_nrate != '0) ? r_nrate : r_def;
    assign sum    = r_prod + PROD_BITS'(r_fq);
    assign left_n = (r_p < r_size) ? (r_size - r_p) : '0;

    // Divider operand selection
    always_comb begin
        div_n = '0;
        div_d = '0;
        unique case (op)
            D_SZMOD:    begin div_n = DIVN_BITS'(r_size);  div_d = DIVD_BITS'(r_frame); end
            D_LSMOD:    begin div_n = DIVN_BITS'(r_loop);  div_d = DIVD_BITS'(r_frame); end
            D_NPMOD:    begin div_n = DIVN_BITS'(r_npos);  div_d = DIVD_BITS'(r_frame); end
            D_FRAMES:   begin div_n = DIVN_BITS'(r_size);  div_d = DIVD_BITS'(r_frame); end
            D_POS:      begin div_n = DIVN_BITS'(r_cur);   div_d = DIVD_BITS'(r_frame); end
            D_REMRATE:  begin div_n = DIVN_BITS'(r_rem);   div_d = DIVD_BITS'(r_rate);  end
            D_LS:       begin div_n = DIVN_BITS'(r_loop);  div_d = DIVD_BITS'(r_frame); end
            D_SECLF:    begin div_n = r_sec;               div_d = r_lf; end
            D_PRODLF:   begin div_n = DIVN_BITS'(r_prod);  div_d = r_lf; end
            D_REMLF:    begin div_n = DIVN_BITS'(r_rem);   div_d = r_lf; end
            D_ADVLF:    begin div_n = DIVN_BITS'(r_t);     div_d = r_lf; end
            D_LEFT:     begin div_n = DIVN_BITS'(left_n);  div_d = DIVD_BITS'(r_frame); end
            default:    ;
        endcase
    end

    // Launch a division once per division op
    assign div_start = is_div(op) && !div_busy && !div_done;

    apct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // Dividend selection for the divide-by-thousand unit
    always_comb begin
        k_n = '0;
        unique case (op)
            D_EL1000:   k_n = r_el;
            D_FRAC1000: k_n = TIME_BITS'(r_prod) + TIME_BITS'(r_frac);
            D_FR1000:   k_n = TIME_BITS'(r_prod) + TIME_BITS'(r_f0);
            default:    ;
        endcase
    end

    assign k_start = is_kdiv(op) && !r_kbusy && !r_kdone;

    // One digit step: remainder and next 16 dividend bits over one thousand
    always_comb begin
        k_t     = {r_kr, r_kx[TIME_BITS-1 -: K_DIG_BITS]};
        k_m     = K_M_BITS'(k_t) * K_M_BITS'(K_MAGIC);
        k_qd    = k_m[K_SHIFT +: K_DIG_BITS];
        k_q1000 = K_T_BITS'(k_qd) * K_T_BITS'(MS_PER_S);
        k_rem   = k_t - k_q1000;
    end

    // Divide-by-thousand sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbusy <= 1'b0;
            r_kdone <= 1'b0;
            r_kcnt  <= '0;
        end else begin
            r_kdone <= 1'b0;
            if (k_start) begin
                r_kbusy <= 1'b1;
                r_kcnt  <= K_CNT_BITS'(K_STEPS - 1);
            end else if (r_kbusy) begin
                if (r_kcnt == '0) begin
                    r_kbusy <= 1'b0;
                    r_kdone <= 1'b1;
                end else begin
                    r_kcnt <= r_kcnt - 1'b1;
                end
            end
        end
    end

    // Shift dividend digits out and quotient digits in
    always_ff @(posedge i_clk) begin
        if (k_start) begin
            r_kx <= k_n;
            r_kr <= '0;
            r_kq <= '0;
        end else if (r_kbusy) begin
            r_kx <= {r_kx[TIME_BITS-K_DIG_BITS-1:0], {K_DIG_BITS{1'b0}}};
            r_kr <= k_rem[FRAC_BITS-1:0];
            r_kq <= {r_kq[TIME_BITS-K_DIG_BITS-1:0], k_qd};
        end
    end

    // Shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            M_ELM:     begin mul_a = SIZE_BITS'(r_elm);         mul_b = r_rate; end
            M_SECRATE: begin mul_a = r_sec[SIZE_BITS-1:0];      mul_b = r_rate; end
            M_S1RATE:  begin mul_a = r_s1;                      mul_b = r_rate; end
            M_ELRATE:  begin mul_a = r_el[SIZE_BITS-1:0];       mul_b = r_rate; end
            M_CURFWD:  begin
                mul_a = r_pos + sum[SIZE_BITS-1:0];
                mul_b = RATE_BITS'(r_frame);
            end
            M_CURLOOP: begin mul_a = r_ls + r_s4;  mul_b = RATE_BITS'(r_frame); end
            M_LEN:     begin mul_a = r_fr;         mul_b = RATE_BITS'(r_frame); end
            default:   ;
        endcase
    end

    assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    // Configuration, persistent state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= RST_BUF_SIZE;
            r_frame     <= RST_FRAME;
            r_loop      <= RST_LOOP_START;
            r_def       <= RST_DEF_RATE;
            r_cur       <= '0;
            r_frac      <= '0;
            r_last      <= '0;
            r_run       <= 1'b0;
            r_loopm     <= 1'b0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_idx))
                    REG_BUF_SIZE:   r_size  <= i_cfg_data;
                    REG_FRAME:      r_frame <= i_cfg_data[FRAME_BITS-1:0];
                    REG_LOOP_START: r_loop  <= i_cfg_data;
                    REG_DEF_RATE:   r_def   <= i_cfg_data[RATE_BITS-1:0];
                    default:        ;
                endcase
            end
            // Raise the result word on finish, drop it once taken
            if (op == OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (op)
                D_FRAC1000: begin
                    if (r_kdone) begin
                        r_frac <= r_kr;
                        r_last <= r_now;
                    end
                end
                M_CURFWD:  r_cur <= mul_p[SIZE_BITS-1:0];
                M_CURLOOP: r_cur <= mul_p[SIZE_BITS-1:0];
                OP_STOPEND: begin
                    r_run  <= 1'b0;
                    r_cur  <= '0;
                    r_frac <= '0;
                end
                OP_INIT: begin
                    r_rate  <= rsel;
                    r_cur   <= '0;
                    r_frac  <= '0;
                    r_last  <= r_now;
                    r_run   <= 1'b0;
                    r_loopm <= 1'b0;
                end
                OP_PLAY: begin
                    if (r_flags[1]) begin
                        r_cur  <= '0;
                        r_frac <= '0;
                    end
                    r_loopm <= r_flags[0];
                    r_run   <= 1'b1;
                    if (r_now > r_last) begin
                        r_last <= r_now;
                    end
                end
                OP_STOP:    r_run <= 1'b0;
                OP_SETPOS: begin
                    r_cur  <= r_npos;
                    r_frac <= '0;
                end
                OP_SETFREQ: r_rate <= rsel;
                default:    ;
            endcase
        end
    end

    // Command capture, temporaries and output word
    always_ff @(posedge i_clk) begin
        unique case (op)
            OP_LOAD: begin
                r_cmd    <= t_cmd'(i_in_data[IN_CMD_LO +: CMD_BITS]);
                r_now    <= i_in_data[IN_NOW_LO +: TIME_BITS];
                r_flags  <= i_in_data[IN_FLAGS_LO +: FLAG_BITS];
                r_npos   <= i_in_data[IN_NPOS_LO +: SIZE_BITS];
                r_nrate  <= i_in_data[IN_RATE_LO +: RATE_BITS];
                r_cvalid <= 1'b0;
            end
            OP_EL: begin
                r_el <= r_now - r_last;
                r_p  <= r_cur;
                r_f0 <= r_frac;
            end
            OP_REM:  r_rem <= (r_pos < r_frames) ? (r_frames - r_pos) : '0;
            OP_LF:   r_lf  <= r_frames - r_ls;
            OP_T:    r_t   <= T_BITS'(r_s2) + T_BITS'(r_fq) + T_BITS'(r_lf) - T_BITS'(r_s3);
            D_SZMOD: if (div_done) r_szok <= (div_r == '0);
            D_LSMOD: if (div_done) r_lsok <= (div_r == '0);
            D_EL1000: begin
                if (r_kdone) begin
                    r_sec <= r_kq;
                    r_elm <= r_kr;
                end
            end
            D_FRAC1000: if (r_kdone)  r_fq     <= r_kq[SIZE_BITS-1:0];
            D_FRAMES:   if (div_done) r_frames <= div_q[SIZE_BITS-1:0];
            D_POS:      if (div_done) r_pos    <= div_q[SIZE_BITS-1:0];
            D_LS:       if (div_done) r_ls     <= div_q[SIZE_BITS-1:0];
            D_SECLF:    if (div_done) r_s1     <= div_r;
            D_PRODLF:   if (div_done) r_s2     <= div_r;
            D_REMLF:    if (div_done) r_s3     <= div_r;
            D_ADVLF:    if (div_done) r_s4     <= div_r;
            D_FR1000:   if (r_kdone)  r_fr     <= r_kq[SIZE_BITS-1:0];
            D_LEFT: begin
                // clamp the due frames to what is left before the end
                if (div_done && (DIVN_BITS'(r_fr) > div_q)) begin
                    r_fr <= div_q[SIZE_BITS-1:0];
                end
            end
            M_ELM, M_SECRATE, M_S1RATE, M_ELRATE: r_prod <= mul_p;
            M_LEN: begin
                r_len    <= mul_p[SIZE_BITS-1:0];
                r_cvalid <= (mul_p[PROD_BITS-1:SIZE_BITS] == '0);
            end
            OP_FINISH: begin
                r_o_status <= i_ctl.status;
                r_o_cur    <= i_ctl.cur_zero ? '0 : r_cur;
                r_o_play   <= r_run;
                r_o_cv     <= r_cvalid;
                r_o_off    <= r_cvalid ? r_p : '0;
                r_o_len    <= r_cvalid ? r_len : '0;
            end
            default: ;
        endcase
    end

    // Status toward the controller
    always_comb begin
        o_sts.cmd          = r_cmd;
        o_sts.div_done     = div_done || r_kdone;
        o_sts.div_rem_zero = (div_r == '0);
        o_sts.cfg_ok       = (r_size != '0) && (r_rate != '0) && (r_frame != '0) &&
                             r_szok && r_lsok && (r_loop < r_size);
        o_sts.init_ok      = (r_size != '0) && (rsel != '0) && (r_frame != '0) && r_szok;
        o_sts.can_adv      = r_run && (r_now > r_last);
        o_sts.cond1        = (r_sec <= div_q);
        o_sts.cond2        = (sum < PROD_BITS'(r_rem));
        o_sts.loop_mode    = r_loopm;
        o_sts.el_in_limit  = (r_el <= TIME_BITS'(STALL_LIMIT_MS));
        o_sts.flags_bad    = (r_flags[FLAG_BITS-1:2] != '0);
        o_sts.npos_ge_size = (r_npos >= r_size);
        o_sts.rsel_zero    = (rsel == '0);
        o_sts.out_busy     = r_out_valid && !i_m_axis_tready;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_BITS-OUT_BITS){1'b0}}, r_o_len, r_o_off,
                              r_o_cv, r_o_play, r_o_cur, r_o_status};

    // A result word only appears after a finish op
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(op == OP_FINISH))
        else $error("output word raised without finish");

    // Finish never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_FINISH) |-> !(r_out_valid && !i_m_axis_tready))
        else $error("pending output word overwritten");

    // Sub-frame remainder stays below one frame
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac < FRAC_BITS'(MS_PER_S))
        else $error("frame remainder out of range");

endmodule

// File: rtl/apct_ctrl.sv
// Controller state machine: sequences the datapath through the checks,
// cursor advance and command updates. Depends on apct_pkg.
module apct_ctrl
    import apct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_sts i_sts,
    output logic o_ready,
    output t_ctl o_ctl
);

    t_state r_state, n_state;
    logic   r_status, n_status;
    logic   r_cur_zero, n_cur_zero;
    logic   r_adv, n_adv;

    // Hold control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_status   <= 1'b0;
            r_cur_zero <= 1'b0;
            r_adv      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_status   <= n_status;
            r_cur_zero <= n_cur_zero;
            r_adv      <= n_adv;
        end
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_cur_zero = r_cur_zero;
        n_adv      = r_adv;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state    = S_CHK_SZ;
                    n_status   = 1'b0;
                    n_cur_zero = 1'b0;
                    n_adv      = 1'b0;
                end
            end
            S_CHK_SZ: if (i_sts.div_done) n_state = S_CHK_LS;
            S_CHK_LS: if (i_sts.div_done) n_state = S_DISPATCH;
            S_DISPATCH: begin
                n_state  = S_FINISH;
                n_status = 1'b1;
                unique case (i_sts.cmd)
                    CMD_INIT: begin
                        if (i_sts.init_ok) begin
                            n_state  = S_APPLY;
                            n_status = 1'b0;
                        end
                    end
                    CMD_QUERY: begin
                        if (i_sts.cfg_ok) begin
                            n_state  = S_A_START;
                            n_status = 1'b0;
                        end else begin
                            n_cur_zero = 1'b1;
                        end
                    end
                    CMD_CONSUME: begin
                        if (i_sts.cfg_ok) begin
                            n_state  = S_A_START;
                            n_status = 1'b0;
                        end
                    end
                    CMD_PLAY: begin
                        if (i_sts.cfg_ok && !i_sts.flags_bad) begin
                            n_state  = S_A_START;
                            n_status = 1'b0;
                        end
                    end
                    CMD_STOP: begin
                        n_status = 1'b0;
                        n_state  = i_sts.cfg_ok ? S_A_START : S_APPLY;
                    end
                    CMD_SETPOS: begin
                        if (i_sts.cfg_ok && !i_sts.npos_ge_size) begin
                            n_state  = S_NPMOD;
                            n_status = 1'b0;
                        end
                    end
                    CMD_SETFREQ: begin
                        if (i_sts.cfg_ok && !i_sts.rsel_zero) begin
                            n_state  = S_A_START;
                            n_status = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            S_NPMOD: begin
                if (i_sts.div_done) begin
                    if (i_sts.div_rem_zero) begin
                        n_state = S_A_START;
                    end else begin
                        n_status = 1'b1;
                        n_state  = S_FINISH;
                    end
                end
            end
            S_A_START: begin
                n_adv   = i_sts.can_adv;
                n_state = i_sts.can_adv ? S_A_EL1000 : S_POST;
            end
            S_A_EL1000:   if (i_sts.div_done) n_state = S_A_MULELM;
            S_A_MULELM:   n_state = S_A_FRAC1000;
            S_A_FRAC1000: if (i_sts.div_done) n_state = S_A_FRAMES;
            S_A_FRAMES:   if (i_sts.div_done) n_state = S_A_POS;
            S_A_POS:      if (i_sts.div_done) n_state = S_A_REM;
            S_A_REM:      n_state = S_A_REMRATE;
            S_A_REMRATE: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.cond1 ? S_A_SECRATE : S_A_WRAP;
                end
            end
            S_A_SECRATE:  n_state = S_A_COND2;
            S_A_COND2:    n_state = i_sts.cond2 ? S_A_CURFWD : S_A_WRAP;
            S_A_CURFWD:   n_state = S_POST;
            S_A_WRAP:     n_state = i_sts.loop_mode ? S_A_LS : S_POST;
            S_A_LS:       if (i_sts.div_done) n_state = S_A_LF;
            S_A_LF:       n_state = S_A_SECLF;
            S_A_SECLF:    if (i_sts.div_done) n_state = S_A_S1RATE;
            S_A_S1RATE:   n_state = S_A_PRODLF;
            S_A_PRODLF:   if (i_sts.div_done) n_state = S_A_REMLF;
            S_A_REMLF:    if (i_sts.div_done) n_state = S_A_T;
            S_A_T:        n_state = S_A_ADVLF;
            S_A_ADVLF:    if (i_sts.div_done) n_state = S_A_CURLOOP;
            S_A_CURLOOP:  n_state = S_POST;
            S_POST: begin
                unique case (i_sts.cmd)
                    CMD_CONSUME: begin
                        n_state = (r_adv && i_sts.el_in_limit) ? S_C_ELRATE : S_FINISH;
                    end
                    CMD_QUERY: n_state = S_FINISH;
                    default:   n_state = S_APPLY;
                endcase
            end
            S_C_ELRATE: n_state = S_C_FR1000;
            S_C_FR1000: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.loop_mode ? S_C_LEN : S_C_LEFT;
                end
            end
            S_C_LEFT: if (i_sts.div_done) n_state = S_C_LEN;
            S_C_LEN:  n_state = S_FINISH;
            S_APPLY:  n_state = S_FINISH;
            S_FINISH: if (!i_sts.out_busy) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_ready          = (r_state == S_IDLE);
        o_ctl.status     = r_status;
        o_ctl.cur_zero   = r_cur_zero;
        o_ctl.op         = OP_NONE;
        unique case (r_state)
            S_IDLE:       o_ctl.op = i_accept ? OP_LOAD : OP_NONE;
            S_CHK_SZ:     o_ctl.op = D_SZMOD;
            S_CHK_LS:     o_ctl.op = D_LSMOD;
            S_NPMOD:      o_ctl.op = D_NPMOD;
            S_A_START:    o_ctl.op = OP_EL;
            S_A_EL1000:   o_ctl.op = D_EL1000;
            S_A_MULELM:   o_ctl.op = M_ELM;
            S_A_FRAC1000: o_ctl.op = D_FRAC1000;
            S_A_FRAMES:   o_ctl.op = D_FRAMES;
            S_A_POS:      o_ctl.op = D_POS;
            S_A_REM:      o_ctl.op = OP_REM;
            S_A_REMRATE:  o_ctl.op = D_REMRATE;
            S_A_SECRATE:  o_ctl.op = M_SECRATE;
            S_A_CURFWD:   o_ctl.op = M_CURFWD;
            S_A_WRAP:     o_ctl.op = i_sts.loop_mode ? OP_NONE : OP_STOPEND;
            S_A_LS:       o_ctl.op = D_LS;
            S_A_LF:       o_ctl.op = OP_LF;
            S_A_SECLF:    o_ctl.op = D_SECLF;
            S_A_S1RATE:   o_ctl.op = M_S1RATE;
            S_A_PRODLF:   o_ctl.op = D_PRODLF;
            S_A_REMLF:    o_ctl.op = D_REMLF;
            S_A_T:        o_ctl.op = OP_T;
            S_A_ADVLF:    o_ctl.op = D_ADVLF;
            S_A_CURLOOP:  o_ctl.op = M_CURLOOP;
            S_C_ELRATE:   o_ctl.op = M_ELRATE;
            S_C_FR1000:   o_ctl.op = D_FR1000;
            S_C_LEFT:     o_ctl.op = D_LEFT;
            S_C_LEN:      o_ctl.op = M_LEN;
            S_APPLY: begin
                unique case (i_sts.cmd)
                    CMD_INIT:    o_ctl.op = OP_INIT;
                    CMD_PLAY:    o_ctl.op = OP_PLAY;
                    CMD_STOP:    o_ctl.op = OP_STOP;
                    CMD_SETPOS:  o_ctl.op = OP_SETPOS;
                    CMD_SETFREQ: o_ctl.op = OP_SETFREQ;
                    default:     o_ctl.op = OP_NONE;
                endcase
            end
            S_FINISH:     o_ctl.op = i_sts.out_busy ? OP_NONE : OP_FINISH;
            default:      o_ctl.op = OP_NONE;
        endcase
    end

    // An accepted word always starts with the register checks
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_state == S_CHK_SZ))
        else $error("accepted word did not start the checks");

    // A finished command frees the input side
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !i_sts.out_busy) |=> (r_state == S_IDLE))
        else $error("finish did not return to idle");

endmodule

// File: rtl/audio_play_cursor_tracker.sv
// Top level of the audio play cursor tracker: stream ports, configuration
// port, controller and datapath. Depends on apct_pkg, apct_ctrl, apct_dp.
//
// One command word in gives one result word out. A command finishes only
// once the previous result no longer waits on the output. Divisions by a
// register value (frame alignment checks, frames and positions, loop wrap
// modulos) run on one shared 48-step restoring divider; divisions by one
// thousand run on a digit unit. Two divider runs always happen for the
// register checks, a set position adds one, a cursor advance adds three
// plus two by one thousand, a wrap into the loop tail five more, and a
// consume one by one thousand plus one more divider run when not looping.
// Input is taken only while no command is in work; a finished result sits
// in the output register and does not block the next input word.
// Configuration writes take effect on the cycle after the write enable.
module audio_play_cursor_tracker
    import apct_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [SIZE_BITS-1:0]      i_cfg_data,
    // command stream
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // cmd, now_ms, play flag bits, new position, new sample rate, zero pad
    input  logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    // result stream
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // status, cursor position, is_playing, consume_valid, consume_offset_bytes,
    // consume_length_bytes, zero pad
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    t_ctl ctl;
    t_sts sts;
    logic ready;
    logic accept;

    // Accept a command word only when the controller is free
    assign o_s_axis_tready = ready;
    assign accept          = i_s_axis_tvalid && ready;

    apct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (sts),
        .o_ready  (ready),
        .o_ctl    (ctl)
    );

    apct_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_data       (i_s_axis_tdata),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// File: bench/audio_play_cursor_tracker_tb.sv
// Self-checking bench for the audio play cursor tracker: command words in,
// result words compared against a cursor predictor. Depends on apct_pkg and the
// top level. Covers directed corner cases, random playback sessions and back-pressure.
module audio_play_cursor_tracker_tb;
    import apct_pkg::*;

    localparam longint unsigned SZ_MASK   = 64'hFF_FFFF;
    localparam longint unsigned TM_MASK   = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned RATE_MASK = 64'hF_FFFF;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int DRAIN_CYCLES  = 1000;
    localparam int HOLD_CYCLES   = 3000;
    localparam logic [CMD_BITS-1:0] CMD_BAD = 3'd7;

    typedef struct {
        logic        status;
        logic [23:0] cursor;
        logic        playing;
        logic        cvalid;
        logic [23:0] offset;
        logic [23:0] length;
    } t_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx;
    logic [SIZE_BITS-1:0]      i_cfg_data;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata;

    audio_play_cursor_tracker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Predictor copy of registers and tracker state
    longint unsigned reg_size, reg_frame, reg_loop, reg_defrate;
    longint unsigned cur_pos, cur_frac, cur_last, cur_rate;
    bit              cur_run, cur_loop;

    t_result cursor_results_q[$];
    int      mismatches;
    int      words_sent;
    int      words_checked;
    int      cycles;
    bit      idle_on;
    bit      hold_req;
    longint unsigned clock_ms;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("audio_play_cursor_tracker_tb NOT OK");
            $finish;
        end
    end

    function automatic bit cfg_ok();
        return reg_size != 0 && cur_rate != 0 && reg_frame != 0 &&
            reg_size % reg_frame == 0 && reg_loop < reg_size &&
            reg_loop % reg_frame == 0;
    endfunction

    // Move the cursor forward by the time elapsed since the last update
    function automatic void advance_cursor(longint unsigned now);
        longint unsigned el, sec, frac, frames, pos, rem, ls, lf, step;
        if (!cfg_ok() || !cur_run || now <= cur_last)
            return;
        el = now - cur_last;
        sec = el / 1000;
        frac = (el % 1000) * cur_rate + cur_frac;
        frames = reg_size / reg_frame;
        pos = cur_pos / reg_frame;
        cur_last = now;
        cur_frac = frac % 1000;
        rem = (pos < frames) ? frames - pos : 0;
        if (sec <= rem / cur_rate && sec * cur_rate + frac / 1000 < rem) begin
            cur_pos = ((pos + sec * cur_rate + frac / 1000) * reg_frame) & SZ_MASK;
            return;
        end
        if (!cur_loop) begin
            cur_run = 0;
            cur_pos = 0;
            cur_frac = 0;
            return;
        end
        // wrap into the loop tail
        ls = reg_loop / reg_frame;
        lf = frames - ls;
        step = ((sec % lf) * cur_rate) % lf + frac / 1000;
        cur_pos = ((ls + (step + lf - rem % lf) % lf) * reg_frame) & SZ_MASK;
    endfunction

    function automatic t_result predict_cursor(logic [2:0] cmd, longint unsigned now,
                                               longint unsigned flags,
                                               longint unsigned npos,
                                               longint unsigned nrate);
        t_result res;
        longint unsigned r, el, p, fr0, fr, left;
        bit zero_cur;
        res = '{default: '0};
        zero_cur = 0;
        case (cmd)
            CMD_INIT: begin
                r = (nrate != 0) ? nrate : reg_defrate;
                if (reg_size == 0 || r == 0 || reg_frame == 0 || reg_size % reg_frame != 0)
                    res.status = 1;
                else begin
                    cur_rate = r;
                    cur_pos = 0;
                    cur_frac = 0;
                    cur_last = now;
                    cur_run = 0;
                    cur_loop = 0;
                end
            end
            CMD_QUERY: begin
                if (!cfg_ok()) begin
                    res.status = 1;
                    zero_cur = 1;
                end else
                    advance_cursor(now);
            end
            CMD_CONSUME: begin
                if (!cfg_ok())
                    res.status = 1;
                else if (cur_run && now > cur_last) begin
                    el = now - cur_last;
                    p = cur_pos;
                    fr0 = cur_frac;
                    advance_cursor(now);
                    if (el <= STALL_LIMIT_MS) begin
                        fr = (el * cur_rate + fr0) / 1000;
                        if (!cur_loop) begin
                            left = (p < reg_size) ? (reg_size - p) / reg_frame : 0;
                            if (fr > left) fr = left;
                        end
                        if (fr <= SZ_MASK / reg_frame) begin
                            res.cvalid = 1;
                            res.offset = p[23:0];
                            res.length = 24'((fr * reg_frame) & SZ_MASK);
                        end
                    end
                end
            end
            CMD_PLAY: begin
                if (!cfg_ok() || (flags & ~64'd3) != 0)
                    res.status = 1;
                else begin
                    advance_cursor(now);
                    if (flags[1]) begin
                        cur_pos = 0;
                        cur_frac = 0;
                    end
                    cur_loop = flags[0];
                    cur_run = 1;
                    if (now > cur_last) cur_last = now;
                end
            end
            CMD_STOP: begin
                advance_cursor(now);
                cur_run = 0;
            end
            CMD_SETPOS: begin
                if (!cfg_ok() || npos >= reg_size || npos % reg_frame != 0)
                    res.status = 1;
                else begin
                    advance_cursor(now);
                    cur_pos = npos;
                    cur_frac = 0;
                end
            end
            CMD_SETFREQ: begin
                r = (nrate != 0) ? nrate : reg_defrate;
                if (!cfg_ok() || r == 0)
                    res.status = 1;
                else begin
                    advance_cursor(now);
                    cur_rate = r;
                end
            end
            default: res.status = 1;
        endcase
        res.cursor = zero_cur ? 24'd0 : cur_pos[23:0];
        res.playing = cur_run;
        return res;
    endfunction

    // Send one command word and record its expected result on acceptance
    task automatic send_cmd(logic [2:0] cmd, longint unsigned now, longint unsigned flags,
                            longint unsigned npos, longint unsigned nrate);
        bit rdy;
        now &= TM_MASK;
        flags &= 64'hFF;
        npos &= SZ_MASK;
        nrate &= RATE_MASK;
        if (idle_on && $urandom_range(99) < 28) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= IN_TDATA_BITS'({nrate[19:0], npos[23:0], flags[7:0],
                                          now[47:0], cmd});
        do begin
            @(negedge i_clk);
            rdy = o_s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        cursor_results_q.push_back(predict_cursor(cmd, now, flags, npos, nrate));
        words_sent++;
    endtask

    // Let every expected result arrive, then let the block settle
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (cursor_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers while the block is idle
    task automatic set_regs(longint unsigned size, longint unsigned frame,
                            longint unsigned lstart, longint unsigned defrate);
        longint unsigned vals[4];
        drain();
        vals = '{size, frame, lstart, defrate};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_IDX_BITS'(k);
            i_cfg_data <= vals[k][23:0];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        reg_size = size & SZ_MASK;
        reg_frame = frame & 64'h7F;
        reg_loop = lstart & SZ_MASK;
        reg_defrate = defrate & RATE_MASK;
    endtask

    // Result checker
    task automatic check_word(logic [OUT_TDATA_BITS-1:0] d);
        t_result ex;
        words_checked++;
        if (cursor_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", d);
            return;
        end
        ex = cursor_results_q.pop_front();
        if (d[0] !== ex.status || d[24:1] !== ex.cursor || d[25] !== ex.playing ||
            d[26] !== ex.cvalid || d[50:27] !== ex.offset || d[74:51] !== ex.length) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp st=%0d cur=%0d play=%0d cv=%0d off=%0d len=%0d / got st=%0d cur=%0d play=%0d cv=%0d off=%0d len=%0d",
                         ex.status, ex.cursor, ex.playing, ex.cvalid, ex.offset, ex.length,
                         d[0], d[24:1], d[25], d[26], d[50:27], d[74:51]);
        end
    endtask

    initial begin : result_side
        bit hs;
        logic [OUT_TDATA_BITS-1:0] d;
        int hold;
        hold = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            hs = o_m_axis_tvalid && i_m_axis_tready;
            d = o_m_axis_tdata;
            @(posedge i_clk);
            if (hs && i_rst_n) check_word(d);
            if (hold_req) begin
                hold = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else
                i_m_axis_tready <= !(idle_on && $urandom_range(99) < 28);
        end
    end

    // Pick a next timestamp: mostly small steps, some stalls, jumps and rewinds
    function automatic longint unsigned next_ms();
        int p;
        p = $urandom_range(99);
        if (p < 70) clock_ms += $urandom_range(0, 60);
        else if (p < 82) clock_ms += $urandom_range(101, 3000);
        else if (p < 88) clock_ms -= $urandom_range(0, 50);
        else if (p < 94) clock_ms = {$urandom, $urandom} & TM_MASK;
        else clock_ms += {$urandom_range(0, 255), $urandom};
        clock_ms &= TM_MASK;
        return clock_ms;
    endfunction

    task automatic random_session(int n);
        int p;
        logic [2:0] cmd;
        longint unsigned flags, npos, nrate;
        send_cmd(CMD_INIT, next_ms(), 0, 0, (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 96000)));
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(99);
            if (p < 40) cmd = CMD_CONSUME;
            else if (p < 54) cmd = CMD_QUERY;
            else if (p < 67) cmd = CMD_PLAY;
            else if (p < 73) cmd = CMD_STOP;
            else if (p < 82) cmd = CMD_SETPOS;
            else if (p < 90) cmd = CMD_SETFREQ;
            else if (p < 97) cmd = CMD_INIT;
            else cmd = CMD_BAD;
            flags = ($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(255);
            if ($urandom_range(99) < 70 && reg_frame != 0 && reg_size >= reg_frame)
                npos = $urandom_range(0, 32'(reg_size / reg_frame - 1)) * reg_frame;
            else
                npos = $urandom;
            p = $urandom_range(99);
            nrate = (p < 15) ? 0 : (p < 60) ? $urandom_range(1, 96000) : $urandom;
            send_cmd(cmd, next_ms(), flags, npos, nrate);
        end
    endtask

    // Commands before any init and with broken register settings
    task automatic test_unconfigured();
        for (int c = 1; c < 8; c++)
            send_cmd(3'(c), 64'd10 * c, 1, 0, 0);
        set_regs(0, 4, 0, 48000);
        send_cmd(CMD_INIT, 5, 0, 0, 0);
        set_regs(4800, 0, 0, 0);
        send_cmd(CMD_INIT, 5, 0, 0, 100);
        set_regs(4801, 4, 0, 0);
        send_cmd(CMD_INIT, 5, 0, 0, 0);
        send_cmd(CMD_INIT, 5, 0, 0, 48000);
        send_cmd(CMD_QUERY, 6, 0, 0, 0);
    endtask

    // Playback, wrap, stall, position and rate corners on a short buffer
    task automatic test_playback();
        set_regs(4800, 4, 2400, 48000);
        send_cmd(CMD_INIT, 1000, 0, 0, 0);
        send_cmd(CMD_PLAY, 1000, 0, 0, 0);
        send_cmd(CMD_CONSUME, 1020, 0, 0, 0);
        send_cmd(CMD_CONSUME, 1090, 0, 0, 0);
        send_cmd(CMD_QUERY, 1200, 0, 0, 0);
        send_cmd(CMD_PLAY, 1200, 1, 0, 0);
        send_cmd(CMD_CONSUME, 1290, 0, 0, 0);
        send_cmd(CMD_CONSUME, 1500, 0, 0, 0);
        send_cmd(CMD_CONSUME, 1400, 0, 0, 0);
        send_cmd(CMD_PLAY, 1500, 8'hFC, 0, 0);
        send_cmd(CMD_PLAY, 1510, 3, 0, 0);
        send_cmd(CMD_SETPOS, 1520, 0, 4796, 0);
        send_cmd(CMD_SETPOS, 1520, 0, 4800, 0);
        send_cmd(CMD_SETPOS, 1520, 0, 6, 0);
        send_cmd(CMD_SETFREQ, 1530, 0, 0, 20'hFFFFF);
        send_cmd(CMD_CONSUME, 1630, 0, 0, 0);
        send_cmd(CMD_SETFREQ, 1640, 0, 0, 0);
        send_cmd(CMD_STOP, TM_MASK, 0, 0, 0);
        send_cmd(CMD_CONSUME, TM_MASK, 0, 0, 0);
        set_regs(4800, 4, 4800, 0);
        send_cmd(CMD_SETFREQ, 10, 0, 0, 0);
        send_cmd(CMD_QUERY, 10, 0, 0, 0);
    endtask

    // Receiver holds off while commands keep coming, then a full pause
    task automatic test_backpressure();
        set_regs(4800, 4, 0, 48000);
        send_cmd(CMD_INIT, 0, 0, 0, 0);
        send_cmd(CMD_PLAY, 0, 1, 0, 0);
        hold_req = 1;
        clock_ms = 0;
        for (int k = 0; k < 20; k++) send_cmd(CMD_CONSUME, next_ms(), 0, 0, 0);
        drain();
    endtask

    task automatic test_random();
        longint unsigned cfgs[11][4];
        int idx;
        cfgs = '{'{4800, 4, 0, 48000}, '{4800, 4, 2400, 48000}, '{1000, 2, 996, 8000},
                 '{16777215, 1, 16777214, 1048575}, '{16777152, 64, 6400, 1},
                 '{960, 64, 320, 44100}, '{1, 1, 0, 1}, '{12700, 127, 0, 8000},
                 '{1001, 4, 0, 22050}, '{100, 4, 100, 8000}, '{4800, 4, 0, 0}};
        for (int ph = 0; ph < 16; ph++) begin
            idx = (ph < 11) ? ph : $urandom_range(0, 7);
            set_regs(cfgs[idx][0], cfgs[idx][1], cfgs[idx][2], cfgs[idx][3]);
            idle_on = (ph != 3);
            random_session(54);
        end
        idle_on = 1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        idle_on = 1;
        hold_req = 0;
        clock_ms = 0;
        reg_size = 65536;
        reg_frame = 4;
        reg_loop = 0;
        reg_defrate = 48000;
        cur_pos = 0;
        cur_frac = 0;
        cur_last = 0;
        cur_rate = 0;
        cur_run = 0;
        cur_loop = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unconfigured();
        test_playback();
        test_backpressure();
        test_random();
        drain();

        $display("ran %0d commands, checked %0d results, %0d mismatches", words_sent,
                 words_checked, mismatches);
        $display("covered unconfigured, stop and loop wrap, stalls, rewinds, register sweeps");
        if (mismatches == 0 && cursor_results_q.size() == 0)
            $display("audio_play_cursor_tracker_tb OK");
        else
            $display("audio_play_cursor_tracker_tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/apct_pkg.sv
rtl/apct_div.sv
rtl/apct_dp.sv
rtl/apct_ctrl.sv
rtl/audio_play_cursor_tracker.sv
bench/audio_play_cursor_tracker_tb.sv
